[rtl/mlf_pkg.sv]
`default_nettype none

package mlf_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int MAX_RESULTS      = 4;

    localparam int FUNC_W     = 2;
    localparam int CH_FIELD_W = 2;
    localparam int LEVEL_W    = 8;
    localparam int TOP_W      = 16;
    localparam int DELAY_W    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // level * top fits in 24 bits; x / 255 == (x * 0x808081) >> 31 for x < 2^24
    localparam int                  PROD_W      = LEVEL_W + TOP_W;
    localparam logic [PROD_W-1:0]   RECIP_255   = 24'h808081;
    localparam int                  RECIP_SHIFT = 31;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TARGET = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_DELAY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP    = 4'd1;

    localparam logic [DELAY_W-1:0] FADE_DELAY_RESET = 8'd0;
    localparam logic [TOP_W-1:0]   PWM_TOP_RESET    = 16'd1023;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] ch;
        logic [LEVEL_W-1:0]    level;
        logic [LEVEL_W-1:0]    target;
        logic                  last;
    } res_req_t;

    typedef struct packed {
        logic [DELAY_W-1:0] fade_delay;
        logic [TOP_W-1:0]   pwm_top;
    } cfg_regs_t;

endpackage

`default_nettype wire

[rtl/mlf_cmd_if.sv]
`default_nettype none

interface mlf_cmd_if
    import mlf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [CH_FIELD_W-1:0] channel;
    logic [LEVEL_W-1:0]    value;

    modport source (output valid, output func, output channel, output value, input ready);
    modport sink (input valid, input func, input channel, input value, output ready);
endinterface

`default_nettype wire

[rtl/mlf_rsp_if.sv]
`default_nettype none

interface mlf_rsp_if
    import mlf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CH_FIELD_W-1:0] out_channel;
    logic [LEVEL_W-1:0]    level;
    logic [LEVEL_W-1:0]    target;
    logic [TOP_W-1:0]      compare_value;
    logic                  output_on;
    logic                  last;

    modport source (
        output valid, output out_channel, output level, output target,
        output compare_value, output output_on, output last, input ready
    );
    modport sink (
        input valid, input out_channel, input level, input target,
        input compare_value, input output_on, input last, output ready
    );
endinterface

`default_nettype wire

[rtl/mlf_cfg_if.sv]
`default_nettype none

interface mlf_cfg_if
    import mlf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/mlf_ram.sv]
`default_nettype none

module mlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/mlf_scale.sv]
`default_nettype none

module mlf_scale
    import mlf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire res_req_t         req,
    input  wire logic [TOP_W-1:0] pwm_top,
    mlf_rsp_if.source             rsp
);

    logic                  s1_vld_reg;
    res_req_t              s1_req_reg;
    logic [PROD_W-1:0]     s1_prod_reg;
    logic                  s2_vld_reg;
    res_req_t              s2_req_reg;
    logic [TOP_W-1:0]      s2_cmp_reg;
    logic                  out_vld_reg;
    res_req_t              out_req_reg;
    logic [TOP_W-1:0]      out_cmp_reg;
    logic [2*PROD_W-1:0]   recip_prod;
    logic                  req_fire;

    assign req_ready  = !s1_vld_reg && !s2_vld_reg && !out_vld_reg;
    assign req_fire   = req_valid && req_ready;
    assign recip_prod = s1_prod_reg * RECIP_255;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= req_fire;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg || (out_vld_reg && !rsp.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg  <= req;
            s1_prod_reg <= PROD_W'(req.level) * PROD_W'(pwm_top);
        end
        if (s1_vld_reg)
        begin
            s2_req_reg <= s1_req_reg;
            s2_cmp_reg <= recip_prod[RECIP_SHIFT +: TOP_W];
        end
        if (s2_vld_reg)
        begin
            out_req_reg <= s2_req_reg;
            out_cmp_reg <= s2_cmp_reg;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.out_channel   = out_req_reg.ch;
    assign rsp.level         = out_req_reg.level;
    assign rsp.target        = out_req_reg.target;
    assign rsp.compare_value = out_cmp_reg;
    assign rsp.output_on     = (out_cmp_reg != '0);
    assign rsp.last          = out_req_reg.last;

    // one result in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_vld_reg, s2_vld_reg, out_vld_reg}))
        else $error("more than one result in scaling pipe");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |=> s2_vld_reg && out_vld_reg == 1'b0 ##1 out_vld_reg)
        else $error("scaling pipe lost a result");

endmodule

`default_nettype wire

[rtl/mlf_ctrl.sv]
`default_nettype none

module mlf_ctrl
    import mlf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    mlf_cmd_if.sink                 cmd,
    input  wire logic [DELAY_W-1:0] fade_delay,
    output logic                    req_valid,
    input  wire logic               req_ready,
    output res_req_t                req
);

    localparam int              CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int              ENTRY_W = 2 * LEVEL_W;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TGT   = 3'd1;
    localparam logic [2:0] S_QRY   = 3'd2;
    localparam logic [2:0] S_WRD   = 3'd3;
    localparam logic [2:0] S_WMOD  = 3'd4;
    localparam logic [2:0] S_WNEXT = 3'd5;
    localparam logic [2:0] S_ISSUE = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CH_FIELD_W-1:0] ch_reg, ch_next;
    logic [LEVEL_W-1:0]    val_reg, val_next;
    logic [CH_W-1:0]       idx_reg, idx_next;
    logic [DELAY_W-1:0]    presc_reg, presc_next;
    res_req_t              pend_reg, pend_next;
    logic                  pend_vld_reg, pend_vld_next;
    res_req_t              req_reg, req_next;
    logic                  ret_walk_reg, ret_walk_next;
    logic [CHANNELS-1:0]   valid_reg, valid_next;
    logic                  rd_vld_reg;

    logic                  rd_en;
    logic [CH_W-1:0]       rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  wr_en;
    logic [CH_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    logic                  cmd_fire;
    logic                  ch_ok;
    logic [CH_W-1:0]       cmd_addr;
    logic [DELAY_W-1:0]    presc_inc;
    logic                  step_due;
    logic [LEVEL_W-1:0]    cur_level;
    logic [LEVEL_W-1:0]    cur_target;
    logic                  moved;
    logic [LEVEL_W-1:0]    new_level;
    logic                  report;

    mlf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign ch_ok     = (32'(cmd.channel) < CHANNELS);
    assign cmd_addr  = CH_W'(cmd.channel);
    assign presc_inc = presc_reg + DELAY_W'(1);
    assign step_due  = (presc_inc >= fade_delay);

    // entries never written read as zero
    assign cur_level  = rd_vld_reg ? rd_data[ENTRY_W-1 -: LEVEL_W] : '0;
    assign cur_target = rd_vld_reg ? rd_data[LEVEL_W-1:0] : '0;
    assign moved      = (cur_level != cur_target);
    assign new_level  = (cur_level < cur_target) ? cur_level + LEVEL_W'(1)
                                                 : cur_level - LEVEL_W'(1);
    assign report     = moved && (32'(idx_reg) < MAX_RESULTS);

    assign req_valid = (state_reg == S_ISSUE);
    assign req       = req_reg;

    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        presc_next    = presc_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        req_next      = req_reg;
        ret_walk_next = ret_walk_reg;
        valid_next    = valid_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = {new_level, cur_target};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.func)
                        FUNC_TICK:
                        begin
                            if (step_due)
                            begin
                                presc_next = '0;
                                idx_next   = '0;
                                state_next = S_WRD;
                            end
                            else
                            begin
                                presc_next = presc_inc;
                            end
                        end
                        FUNC_SET:
                        begin
                            if (ch_ok)
                            begin
                                wr_en                = 1'b1;
                                wr_addr              = cmd_addr;
                                wr_data              = {cmd.value, cmd.value};
                                valid_next[cmd_addr] = 1'b1;
                                req_next.ch          = cmd.channel;
                                req_next.level       = cmd.value;
                                req_next.target      = cmd.value;
                                req_next.last        = 1'b1;
                                ret_walk_next        = 1'b0;
                                state_next           = S_ISSUE;
                            end
                        end
                        FUNC_TARGET:
                        begin
                            if (ch_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cmd_addr;
                                ch_next    = cmd.channel;
                                val_next   = cmd.value;
                                state_next = S_TGT;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (ch_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cmd_addr;
                                ch_next    = cmd.channel;
                                state_next = S_QRY;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TGT:
            begin
                wr_en                     = 1'b1;
                wr_addr                   = CH_W'(ch_reg);
                wr_data                   = {cur_level, val_reg};
                valid_next[CH_W'(ch_reg)] = 1'b1;
                state_next                = S_IDLE;
            end
            S_QRY:
            begin
                req_next.ch     = ch_reg;
                req_next.level  = cur_level;
                req_next.target = cur_target;
                req_next.last   = 1'b1;
                ret_walk_next   = 1'b0;
                state_next      = S_ISSUE;
            end
            S_WRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_WMOD;
            end
            S_WMOD:
            begin
                state_next = S_WNEXT;
                if (moved)
                begin
                    wr_en               = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                end
                // hold the newest report back until it is known whether it is the last
                if (report)
                begin
                    pend_next.ch     = CH_FIELD_W'(idx_reg);
                    pend_next.level  = new_level;
                    pend_next.target = cur_target;
                    pend_next.last   = 1'b0;
                    pend_vld_next    = 1'b1;
                    if (pend_vld_reg)
                    begin
                        req_next      = pend_reg;
                        ret_walk_next = 1'b1;
                        state_next    = S_ISSUE;
                    end
                end
            end
            S_WNEXT:
            begin
                if (idx_reg == LAST_CH)
                begin
                    state_next = S_IDLE;
                    if (pend_vld_reg)
                    begin
                        req_next      = pend_reg;
                        req_next.last = 1'b1;
                        pend_vld_next = 1'b0;
                        ret_walk_next = 1'b0;
                        state_next    = S_ISSUE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CH_W'(1);
                    state_next = S_WRD;
                end
            end
            S_ISSUE:
            begin
                if (req_ready)
                begin
                    state_next = ret_walk_reg ? S_WNEXT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            presc_reg    <= '0;
            pend_vld_reg <= 1'b0;
            ret_walk_reg <= 1'b0;
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            presc_reg    <= presc_next;
            pend_vld_reg <= pend_vld_next;
            ret_walk_reg <= ret_walk_next;
            valid_reg    <= valid_next;
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        val_reg  <= val_next;
        pend_reg <= pend_next;
        req_reg  <= req_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("state ram read and write hit the same entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (state_reg != S_IDLE && state_reg != S_TGT && state_reg != S_QRY))
        else $error("held fade report outside a fade walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.func == FUNC_TICK && step_due) |=> (presc_reg == '0))
        else $error("prescaler not cleared on fade step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(idx_reg) < CHANNELS))
        else $error("walk index beyond channel count");

endmodule

`default_nettype wire

[rtl/multichannel_led_fader_core.sv]
`default_nettype none

// channel  dir  handshake       payload
// cfg      in   valid/ready     index, data (fade_delay, pwm_top)
// cmd      in   valid/ready     func, channel, value
// rsp      out  valid/ready     out_channel, level, target, compare_value, output_on, last
//
// levels and targets live in one state ram with a registered read
// set-target: read, then write; set-now: write, then issue; query: read, build, then issue
// fade step: read, update and advance states for each channel walked, plus result issue
// each result passes through the scale pipe (level*top, then reciprocal of 255)
// a result issues only once the scale pipe is empty, so results wait on a stalled rsp
// reset clears control state and per-channel valid bits; no ram clearing pass
// a stalled rsp holds its item in the output register; cmd items are taken only in idle,
// so none are taken once the next result has to issue

module multichannel_led_fader_core
    import mlf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mlf_cfg_if.sink   cfg,
    mlf_cmd_if.sink   cmd,
    mlf_rsp_if.source rsp
);

    cfg_regs_t cfg_reg;
    logic      req_valid;
    logic      req_ready;
    res_req_t  req;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_delay <= FADE_DELAY_RESET;
            cfg_reg.pwm_top    <= PWM_TOP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_FADE_DELAY:
                begin
                    cfg_reg.fade_delay <= cfg.data[DELAY_W-1:0];
                end
                REG_PWM_TOP:
                begin
                    cfg_reg.pwm_top <= cfg.data[TOP_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    mlf_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .fade_delay (cfg_reg.fade_delay),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req)
    );

    mlf_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pwm_top   (cfg_reg.pwm_top),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[bench/fade_checker.sv]
`timescale 1ns / 1ps

module fade_checker
    import mlf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mlf_cfg_if        cfg,
    mlf_cmd_if        cmd,
    mlf_rsp_if        rsp,
    output int        errors,
    output int        pending
);

    typedef struct packed {
        logic [CH_FIELD_W-1:0] ch;
        logic [LEVEL_W-1:0]    level;
        logic [LEVEL_W-1:0]    target;
        logic [TOP_W-1:0]      compare;
        logic                  on;
        logic                  last;
    } fade_report_t;

    logic [LEVEL_W-1:0] level_now  [CHANNELS];
    logic [LEVEL_W-1:0] level_goal [CHANNELS];
    logic [DELAY_W-1:0] prescale;
    logic [DELAY_W-1:0] fade_delay;
    logic [TOP_W-1:0]   pwm_top;
    fade_report_t       expected_reports[$];
    int                 mismatches;

    function automatic fade_report_t channel_report(int ch, logic last);
        fade_report_t r;
        logic [31:0]  product;
        product   = (32'(level_now[ch]) * 32'(pwm_top)) / 32'd255;
        r.ch      = CH_FIELD_W'(ch);
        r.level   = level_now[ch];
        r.target  = level_goal[ch];
        r.compare = product[TOP_W-1:0];
        r.on      = (product != 0);
        r.last    = last;
        return r;
    endfunction

    function automatic string show(fade_report_t r);
        return $sformatf("ch %0d level %0d target %0d cmp %0d on %0d last %0d",
                         r.ch, r.level, r.target, r.compare, r.on, r.last);
    endfunction

    task automatic note_failure(string what);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic fade_or_set(logic [FUNC_W-1:0] func, logic [CH_FIELD_W-1:0] ch,
                               logic [LEVEL_W-1:0] value);
        int moved [MAX_RESULTS];
        int n;
        n = 0;
        if (func == FUNC_TICK)
        begin
            prescale = prescale + 1'b1;
            if (prescale >= fade_delay)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (level_now[i] != level_goal[i])
                    begin
                        if (level_now[i] < level_goal[i])
                            level_now[i] = level_now[i] + 1'b1;
                        else
                            level_now[i] = level_now[i] - 1'b1;
                        // only channels the result field can name are reported, at most MAX_RESULTS of them
                        if (i < (1 << CH_FIELD_W) && n < MAX_RESULTS)
                        begin
                            moved[n] = i;
                            n++;
                        end
                    end
                end
                prescale = '0;
            end
            for (int k = 0; k < n; k++)
                expected_reports.push_back(channel_report(moved[k], k == n - 1));
        end
        else if (int'(ch) < CHANNELS)
        begin
            case (func)
                FUNC_SET:
                begin
                    level_now[ch]  = value;
                    level_goal[ch] = value;
                    expected_reports.push_back(channel_report(ch, 1'b1));
                end
                FUNC_TARGET:
                    level_goal[ch] = value;
                default:
                    expected_reports.push_back(channel_report(ch, 1'b1));
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fade_report_t seen;
        fade_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                level_now[i]  = '0;
                level_goal[i] = '0;
            end
            prescale   = '0;
            fade_delay = FADE_DELAY_RESET;
            pwm_top    = PWM_TOP_RESET;
            expected_reports.delete();
            mismatches = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                seen = {rsp.out_channel, rsp.level, rsp.target, rsp.compare_value,
                        rsp.output_on, rsp.last};
                if (expected_reports.size() == 0)
                    note_failure($sformatf("unexpected item: %s", show(seen)));
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen !== want)
                        note_failure($sformatf("mismatch: expected %s, got %s",
                                               show(want), show(seen)));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FADE_DELAY: fade_delay = cfg.data[DELAY_W-1:0];
                    REG_PWM_TOP:    pwm_top    = cfg.data[TOP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
                fade_or_set(cmd.func, cmd.channel, cmd.value);
        end
        errors  = mismatches;
        pending = expected_reports.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mlf_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic calm;
    int   cycle_count = 0;
    int   mismatch_count;
    int   outstanding;

    mlf_cfg_if cfg_ch ();
    mlf_cmd_if cmd_ch ();
    mlf_rsp_if rsp_ch ();

    multichannel_led_fader_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    fade_checker monitor (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .errors  (mismatch_count),
        .pending (outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 8);
        cycle_count  <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_item(logic [FUNC_W-1:0] func, logic [CH_FIELD_W-1:0] ch,
                             logic [LEVEL_W-1:0] value);
        while (!calm && $urandom_range(99) < 8)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.func    <= func;
        cmd_ch.channel <= ch;
        cmd_ch.value   <= value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic await_cfg();
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // fade_delay, pwm_top, then a write to an unused index
    task automatic write_settings(logic [DELAY_W-1:0] delay, logic [TOP_W-1:0] top);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_FADE_DELAY;
        cfg_ch.data  <= CFG_DATA_W'(delay) | (CFG_DATA_W'($urandom) << DELAY_W);
        await_cfg();
        cfg_ch.index <= REG_PWM_TOP;
        cfg_ch.data  <= top;
        await_cfg();
        cfg_ch.index <= CFG_IDX_W'($urandom_range(REG_PWM_TOP + 1, (1 << CFG_IDX_W) - 1));
        cfg_ch.data  <= CFG_DATA_W'($urandom);
        await_cfg();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_items(int count, int tick_pct);
        logic [FUNC_W-1:0] func;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(9);
            if ($urandom_range(99) < tick_pct)
                func = FUNC_TICK;
            else if (pick < 3)
                func = FUNC_SET;
            else if (pick < 7)
                func = FUNC_TARGET;
            else
                func = FUNC_QUERY;
            send_item(func, CH_FIELD_W'($urandom), LEVEL_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        calm           = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.func    = FUNC_TICK;
        cmd_ch.channel = '0;
        cmd_ch.value   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_FADE_DELAY;
        cfg_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset state, extremes, fades, a step with nothing to move
        for (int c = 0; c < 4; c++)
            send_item(FUNC_QUERY, CH_FIELD_W'(c), '0);
        send_item(FUNC_SET, 0, 255);
        send_item(FUNC_SET, 1, 0);
        send_item(FUNC_SET, 2, 1);
        send_item(FUNC_SET, 3, 128);
        send_item(FUNC_TARGET, 0, 0);
        send_item(FUNC_TARGET, 1, 255);
        send_item(FUNC_TARGET, 2, 1);
        send_item(FUNC_TARGET, 3, 127);
        send_item(FUNC_TICK, 3, 255);
        send_item(FUNC_TICK, 0, 0);
        send_item(FUNC_SET, 0, 0);
        send_item(FUNC_SET, 1, 255);
        send_item(FUNC_TICK, 1, 170);
        send_item(FUNC_TARGET, 2, 0);
        send_item(FUNC_TICK, 2, 85);
        send_item(FUNC_QUERY, 1, 255);

        // zero top: compare stays zero, output off
        settle();
        write_settings('0, '0);
        random_items(40, 40);

        settle();
        write_settings('1, '1);
        random_items(200, 97);

        settle();
        calm <= 1'b1;
        write_settings(1, 1);
        random_items(60, 40);

        settle();
        calm <= 1'b0;
        write_settings(2, 255);
        random_items(50, 40);

        for (int p = 0; p < 2; p++)
        begin
            settle();
            write_settings(DELAY_W'($urandom_range(0, 9)), TOP_W'($urandom_range(1, 65535)));
            random_items(40, 40);
        end

        settle();
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
